### sv/msblit_pkg.sv
// Shared types and constants for the masked scaled sprite blit.
package msblit_pkg;

  // Widths fixed by the register and field definitions.
  localparam int unsigned SCALE_BITS  = 4;
  localparam int unsigned MARGIN_BITS = 10;
  localparam int unsigned VIEW_BITS   = 11;
  localparam int unsigned PITCH_BITS  = 13;
  localparam int unsigned SURF_BITS   = 12;
  localparam int unsigned ADDR_BITS   = 24;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam logic [7:0]  MASK_LIMIT  = 8'd128;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_OUTSIDE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN_X     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN_Y     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_PITCH   = 3'd6;

  typedef struct packed {
    logic [SCALE_BITS-1:0]  scale;
    logic                   draw_outside;
    logic [MARGIN_BITS-1:0] margin_x;
    logic [MARGIN_BITS-1:0] margin_y;
    logic [VIEW_BITS-1:0]   view_width;
    logic [VIEW_BITS-1:0]   view_height;
    logic [PITCH_BITS-1:0]  line_pitch;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLIP,
    ST_BASE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic load;
    logic clip;
    logic base;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic empty;
    logic at_last;
    logic out_free;
  } dp_sts_t;

endpackage

### sv/msblit_cfg.sv
// Configuration registers of the sprite blit.
module msblit_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [msblit_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [msblit_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output msblit_pkg::cfg_t                      cfg_o
);
  import msblit_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCALE:        cfg_d.scale        = cfg_wdata_i[SCALE_BITS-1:0];
        REG_DRAW_OUTSIDE: cfg_d.draw_outside = cfg_wdata_i[0];
        REG_MARGIN_X:     cfg_d.margin_x     = cfg_wdata_i[MARGIN_BITS-1:0];
        REG_MARGIN_Y:     cfg_d.margin_y     = cfg_wdata_i[MARGIN_BITS-1:0];
        REG_VIEW_WIDTH:   cfg_d.view_width   = cfg_wdata_i[VIEW_BITS-1:0];
        REG_VIEW_HEIGHT:  cfg_d.view_height  = cfg_wdata_i[VIEW_BITS-1:0];
        REG_LINE_PITCH:   cfg_d.line_pitch   = cfg_wdata_i[PITCH_BITS-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale        <= SCALE_BITS'(2);
      cfg_q.draw_outside <= 1'b0;
      cfg_q.margin_x     <= '0;
      cfg_q.margin_y     <= '0;
      cfg_q.view_width   <= VIEW_BITS'(640);
      cfg_q.view_height  <= VIEW_BITS'(480);
      cfg_q.line_pitch   <= PITCH_BITS'(640);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/msblit_ctrl.sv
// Sequencer for the sprite blit: load, clip, row base setup and write loop.
module msblit_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  msblit_pkg::dp_sts_t  sts_i,
  output msblit_pkg::dp_cmd_t  cmd_o
);
  import msblit_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = ST_CLIP;
      end
      ST_CLIP: begin
        state_d = sts_i.drop ? ST_IDLE : ST_BASE;
      end
      ST_BASE: begin
        state_d = sts_i.empty ? ST_IDLE : ST_RUN;
      end
      ST_RUN: if (sts_i.out_free && sts_i.at_last) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CLIP: cmd_o.clip = 1'b1;
      ST_BASE: cmd_o.base = 1'b1;
      ST_RUN:  cmd_o.step = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/msblit_dp.sv
// Datapath of the sprite blit: texel checks, clipping, address walk, output register.
module msblit_dp #(
  parameter int unsigned PALETTE_ENTRIES = 16,
  parameter int unsigned MAX_SCALE       = 8,
  parameter int unsigned COORD_BITS      = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  msblit_pkg::cfg_t                    cfg_i,
  input  msblit_pkg::dp_cmd_t                 cmd_i,
  output msblit_pkg::dp_sts_t                 sts_o,
  input  logic signed [COORD_BITS-1:0]        origin_x_i,
  input  logic signed [COORD_BITS-1:0]        origin_y_i,
  input  logic [11:0]                         rect_x_i,
  input  logic [11:0]                         rect_y_i,
  input  logic [7:0]                          texel_u_i,
  input  logic [7:0]                          texel_v_i,
  input  logic [12:0]                         image_width_i,
  input  logic [12:0]                         image_height_i,
  input  logic [7:0]                          mask_byte_i,
  input  logic [7:0]                          color_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [msblit_pkg::ADDR_BITS-1:0]    write_address_o,
  output logic [7:0]                          write_color_o,
  output logic                                last_o
);
  import msblit_pkg::*;

  // Signed working width for destination coordinates.
  localparam int unsigned PW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 3;

  // Item registers.
  logic [SCALE_BITS-1:0]  s_q, s_d;
  logic signed [PW-1:0]   bx_q, bx_d, by_q, by_d;
  logic [7:0]             color_q, color_d;
  logic                   drop_q, drop_d;
  // Clipped region in surface coordinates.
  logic [SURF_BITS-1:0]   sx_lo_q, sx_lo_d, sx_last_q, sx_last_d;
  logic [SURF_BITS-1:0]   sy_lo_q, sy_lo_d, sy_last_q, sy_last_d;
  logic                   empty_q, empty_d;
  // Walk counters.
  logic [SURF_BITS-1:0]   sx_q, sx_d, sy_q, sy_d;
  logic [ADDR_BITS-1:0]   row_base_q, row_base_d;
  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [ADDR_BITS-1:0]   addr_q, addr_d;
  logic [7:0]             wcolor_q, wcolor_d;
  logic                   last_q, last_d;

  logic [SCALE_BITS-1:0]  s_eff;
  logic [11:0]            us, vs;
  logic [12:0]            src_x, src_y;
  logic signed [PW-1:0]   off_x, off_y, lo_x, lo_y, hi_x, hi_y;
  logic signed [PW-1:0]   bxe, bye, xlo, xhi, ylo, yhi, s_ext;
  logic                   at_last, row_end;
  logic [ADDR_BITS-1:0]   row_prod;

  // Scale of zero acts as one; anything above the maximum saturates.
  always_comb begin
    s_eff = cfg_i.scale;
    if (cfg_i.scale == '0) begin
      s_eff = SCALE_BITS'(1);
    end else if (cfg_i.scale > SCALE_BITS'(MAX_SCALE)) begin
      s_eff = SCALE_BITS'(MAX_SCALE);
    end
  end

  assign us    = 12'(texel_u_i) * 12'(s_eff);
  assign vs    = 12'(texel_v_i) * 12'(s_eff);
  assign src_x = 13'(rect_x_i) + 13'(texel_u_i);
  assign src_y = 13'(rect_y_i) + 13'(texel_v_i);

  // Clip window, viewport or viewport plus margins.
  always_comb begin
    off_x = cfg_i.draw_outside ? $signed({{(PW-MARGIN_BITS){1'b0}}, cfg_i.margin_x}) : '0;
    off_y = cfg_i.draw_outside ? $signed({{(PW-MARGIN_BITS){1'b0}}, cfg_i.margin_y}) : '0;
    lo_x  = -off_x;
    lo_y  = -off_y;
    hi_x  = $signed({{(PW-VIEW_BITS){1'b0}}, cfg_i.view_width}) + off_x;
    hi_y  = $signed({{(PW-VIEW_BITS){1'b0}}, cfg_i.view_height}) + off_y;
    s_ext = $signed({{(PW-SCALE_BITS){1'b0}}, s_q});
    bxe   = bx_q + s_ext;
    bye   = by_q + s_ext;
    xlo   = (bx_q > lo_x) ? bx_q : lo_x;
    ylo   = (by_q > lo_y) ? by_q : lo_y;
    xhi   = (bxe < hi_x) ? bxe : hi_x;
    yhi   = (bye < hi_y) ? bye : hi_y;
  end

  assign row_prod = ADDR_BITS'(sy_lo_q) * ADDR_BITS'(cfg_i.line_pitch);
  assign row_end  = (sx_q == sx_last_q);
  assign at_last  = row_end && (sy_q == sy_last_q);

  always_comb begin
    s_d        = s_q;
    bx_d       = bx_q;
    by_d       = by_q;
    color_d    = color_q;
    drop_d     = drop_q;
    sx_lo_d    = sx_lo_q;
    sx_last_d  = sx_last_q;
    sy_lo_d    = sy_lo_q;
    sy_last_d  = sy_last_q;
    empty_d    = empty_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    row_base_d = row_base_q;
    addr_d     = addr_q;
    wcolor_d   = wcolor_q;
    last_d     = last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.load) begin
      s_d     = s_eff;
      bx_d    = PW'(origin_x_i) + $signed({{(PW-12){1'b0}}, us});
      by_d    = PW'(origin_y_i) + $signed({{(PW-12){1'b0}}, vs});
      color_d = color_i;
      drop_d  = ({1'b0, color_i} >= 9'(PALETTE_ENTRIES)) ||
                (src_x >= image_width_i) || (src_y >= image_height_i) ||
                (mask_byte_i > MASK_LIMIT);
    end

    if (cmd_i.clip) begin
      empty_d   = (xlo >= xhi) || (ylo >= yhi);
      sx_lo_d   = SURF_BITS'(xlo + off_x);
      sx_last_d = SURF_BITS'(xhi + off_x - PW'(1));
      sy_lo_d   = SURF_BITS'(ylo + off_y);
      sy_last_d = SURF_BITS'(yhi + off_y - PW'(1));
    end

    if (cmd_i.base) begin
      row_base_d = row_prod;
      sx_d       = sx_lo_q;
      sy_d       = sy_lo_q;
    end

    if (cmd_i.step) begin
      out_valid_d = 1'b1;
      addr_d      = row_base_q + ADDR_BITS'(sx_q);
      wcolor_d    = color_q;
      last_d      = at_last;
      if (row_end) begin
        sx_d       = sx_lo_q;
        sy_d       = sy_q + SURF_BITS'(1);
        row_base_d = row_base_q + ADDR_BITS'(cfg_i.line_pitch);
      end else begin
        sx_d = sx_q + SURF_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    bx_q       <= bx_d;
    by_q       <= by_d;
    color_q    <= color_d;
    drop_q     <= drop_d;
    sx_lo_q    <= sx_lo_d;
    sx_last_q  <= sx_last_d;
    sy_lo_q    <= sy_lo_d;
    sy_last_q  <= sy_last_d;
    empty_q    <= empty_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    row_base_q <= row_base_d;
    addr_q     <= addr_d;
    wcolor_q   <= wcolor_d;
    last_q     <= last_d;
  end

  assign sts_o.drop     = drop_q;
  assign sts_o.empty    = empty_q;
  assign sts_o.at_last  = at_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign write_address_o = addr_q;
  assign write_color_o   = wcolor_q;
  assign last_o          = last_q;

endmodule

### sv/masked_scaled_sprite_blit_top.sv
// Per texel: load in idle, clip state, row base state, then the write loop into the single
// output register, up to MAX_SCALE squared writes. A dropped texel returns to idle after
// clip, a fully clipped one after row base. One write per cycle while out_ready_i is high;
// a new texel is taken once the previous one has issued its last write.
// Reset (asynchronous, active low) clears the sequencer and the output valid and loads the
// register defaults: scale 2, no margins, viewport 640 x 480, line pitch 640.
module masked_scaled_sprite_blit_top #(
  parameter int unsigned PALETTE_ENTRIES = 16,
  parameter int unsigned MAX_SCALE       = 8,
  parameter int unsigned COORD_BITS      = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [msblit_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [msblit_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_BITS-1:0]          origin_x_i,
  input  logic signed [COORD_BITS-1:0]          origin_y_i,
  input  logic [11:0]                           rect_x_i,
  input  logic [11:0]                           rect_y_i,
  input  logic [7:0]                            texel_u_i,
  input  logic [7:0]                            texel_v_i,
  input  logic [12:0]                           image_width_i,
  input  logic [12:0]                           image_height_i,
  input  logic [7:0]                            mask_byte_i,
  input  logic [7:0]                            color_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [msblit_pkg::ADDR_BITS-1:0]      write_address_o,
  output logic [7:0]                            write_color_o,
  output logic                                  last_o
);
  import msblit_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  msblit_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  msblit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msblit_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_SCALE       (MAX_SCALE),
    .COORD_BITS      (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .rect_x_i        (rect_x_i),
    .rect_y_i        (rect_y_i),
    .texel_u_i       (texel_u_i),
    .texel_v_i       (texel_v_i),
    .image_width_i   (image_width_i),
    .image_height_i  (image_height_i),
    .mask_byte_i     (mask_byte_i),
    .color_i         (color_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_address_o (write_address_o),
    .write_color_o   (write_color_o),
    .last_o          (last_o)
  );

endmodule

### test/tb_top.sv
// Self-checking testbench for the masked scaled sprite blit: texel beats in, layer writes out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msblit_pkg::*;

  localparam int PALETTE_ENTRIES = 16;
  localparam int MAX_SCALE       = 8;
  localparam int COORD_BITS      = 12;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;

  localparam int TEXEL_GOOD   = 0;
  localparam int TEXEL_BROKEN = 1;
  localparam int TEXEL_NOISE  = 2;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [7:0]  texel_u;
    logic [7:0]  texel_v;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [7:0]  mask_byte;
    logic [7:0]  color;
  } texel_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           color;
    logic                 last;
  } layer_write_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [COORD_BITS-1:0]  origin_x_i = '0;
  logic signed [COORD_BITS-1:0]  origin_y_i = '0;
  logic [11:0]                   rect_x_i = '0;
  logic [11:0]                   rect_y_i = '0;
  logic [7:0]                    texel_u_i = '0;
  logic [7:0]                    texel_v_i = '0;
  logic [12:0]                   image_width_i = '0;
  logic [12:0]                   image_height_i = '0;
  logic [7:0]                    mask_byte_i = '0;
  logic [7:0]                    color_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [ADDR_BITS-1:0]          write_address_o;
  logic [7:0]                    write_color_o;
  logic                          last_o;

  masked_scaled_sprite_blit_top #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .MAX_SCALE      (MAX_SCALE),
    .COORD_BITS     (COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .texel_u_i      (texel_u_i),
    .texel_v_i      (texel_v_i),
    .image_width_i  (image_width_i),
    .image_height_i (image_height_i),
    .mask_byte_i    (mask_byte_i),
    .color_i        (color_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_address_o(write_address_o),
    .write_color_o  (write_color_o),
    .last_o         (last_o)
  );

  cfg_t         blit_cfg;
  layer_write_t expected_writes[$];
  int           send_idle_pct = 32;
  int           recv_idle_pct = 74;
  int           error_count = 0;
  int           texels_sent = 0;
  int           texels_dropped = 0;
  int           texels_clipped = 0;
  int           writes_checked = 0;
  int           settings_loaded = 0;
  int           quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Expand one texel into its layer writes under the current register settings.
  // Returns -1 when the texel is dropped, otherwise the number of writes queued.
  function automatic int expand_texel(texel_t t);
    int s, offx, offy, lox, loy, hix, hiy, ox, oy, u, v, px, py, dx, dy, n;
    longint addr;
    layer_write_t w;
    if (int'(t.color) >= PALETTE_ENTRIES) return -1;
    if (int'(t.rect_x) + int'(t.texel_u) >= int'(t.image_width)) return -1;
    if (int'(t.rect_y) + int'(t.texel_v) >= int'(t.image_height)) return -1;
    if (t.mask_byte > MASK_LIMIT) return -1;
    s = int'(blit_cfg.scale);
    if (s < 1) s = 1;
    if (s > MAX_SCALE) s = MAX_SCALE;
    offx = blit_cfg.draw_outside ? int'(blit_cfg.margin_x) : 0;
    offy = blit_cfg.draw_outside ? int'(blit_cfg.margin_y) : 0;
    lox = -offx;
    loy = -offy;
    hix = int'(blit_cfg.view_width) + offx;
    hiy = int'(blit_cfg.view_height) + offy;
    ox = int'($signed(t.origin_x));
    oy = int'($signed(t.origin_y));
    u = int'(t.texel_u);
    v = int'(t.texel_v);
    n = 0;
    for (dy = 0; dy < s; dy++) begin
      py = oy + v * s + dy;
      if (py < loy || py >= hiy) continue;
      for (dx = 0; dx < s; dx++) begin
        px = ox + u * s + dx;
        if (px < lox || px >= hix) continue;
        addr = longint'(py + offy) * longint'(blit_cfg.line_pitch) + longint'(px + offx);
        w.address = ADDR_BITS'(addr);
        w.color = t.color;
        w.last = 1'b0;
        expected_writes.push_back(w);
        n++;
      end
    end
    if (n > 0) expected_writes[expected_writes.size() - 1].last = 1'b1;
    return n;
  endfunction

  function automatic texel_t make_texel(int ox, int oy, int rx, int ry, int u, int v,
                                        int iw, int ih, int mask, int color);
    texel_t t;
    t.origin_x = 12'(ox);
    t.origin_y = 12'(oy);
    t.rect_x = 12'(rx);
    t.rect_y = 12'(ry);
    t.texel_u = 8'(u);
    t.texel_v = 8'(v);
    t.image_width = 13'(iw);
    t.image_height = 13'(ih);
    t.mask_byte = 8'(mask);
    t.color = 8'(color);
    return t;
  endfunction

  function automatic cfg_t make_settings(int sc, int draw, int mx, int my, int vw, int vh,
                                         int pitch);
    cfg_t c;
    c.scale = SCALE_BITS'(sc);
    c.draw_outside = 1'(draw);
    c.margin_x = MARGIN_BITS'(mx);
    c.margin_y = MARGIN_BITS'(my);
    c.view_width = VIEW_BITS'(vw);
    c.view_height = VIEW_BITS'(vh);
    c.line_pitch = PITCH_BITS'(pitch);
    return c;
  endfunction

  function automatic cfg_t random_settings();
    int sc, r, mx, my, vw, vh;
    r = int'($urandom_range(0, 9));
    if (r < 7) sc = int'($urandom_range(1, 4));
    else if (r < 9) sc = int'($urandom_range(5, 8));
    else sc = int'($urandom_range(0, 15));
    mx = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 1023)) : int'($urandom_range(0, 16));
    my = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 1023)) : int'($urandom_range(0, 16));
    r = int'($urandom_range(0, 9));
    if (r < 5) begin
      vw = int'($urandom_range(1, 64));
      vh = int'($urandom_range(1, 64));
    end else if (r < 9) begin
      vw = int'($urandom_range(1, 2047));
      vh = int'($urandom_range(1, 2047));
    end else begin
      vw = int'($urandom_range(0, 3));
      vh = int'($urandom_range(0, 3));
    end
    return make_settings(sc, int'($urandom_range(0, 1)), mx, my, vw, vh,
                         int'($urandom_range(0, 8191)));
  endfunction

  // A well-formed texel lands near the drawable area so that clipping edges are hit often.
  function automatic texel_t random_texel(int kind);
    texel_t t;
    int s, offx, offy, iw, ih, posx, posy, ulim, vlim, u, v, tx, ty, ox, oy, rx, ry, hx, hy;
    if (kind == TEXEL_NOISE) begin
      t.origin_x = 12'($urandom);
      t.origin_y = 12'($urandom);
      t.rect_x = 12'($urandom);
      t.rect_y = 12'($urandom);
      t.texel_u = 8'($urandom);
      t.texel_v = 8'($urandom);
      t.image_width = 13'($urandom);
      t.image_height = 13'($urandom);
      t.mask_byte = 8'($urandom);
      t.color = 8'($urandom);
      return t;
    end
    s = int'(blit_cfg.scale);
    if (s < 1) s = 1;
    if (s > MAX_SCALE) s = MAX_SCALE;
    offx = blit_cfg.draw_outside ? int'(blit_cfg.margin_x) : 0;
    offy = blit_cfg.draw_outside ? int'(blit_cfg.margin_y) : 0;
    iw = int'($urandom_range(1, 4096));
    ih = int'($urandom_range(1, 4096));
    posx = int'($urandom_range(0, iw - 1));
    posy = int'($urandom_range(0, ih - 1));
    ulim = (posx < 255) ? posx : 255;
    vlim = (posy < 255) ? posy : 255;
    if ($urandom_range(0, 9) < 7 && ulim > 7) ulim = 7;
    if ($urandom_range(0, 9) < 7 && vlim > 7) vlim = 7;
    u = int'($urandom_range(0, ulim));
    v = int'($urandom_range(0, vlim));
    rx = posx - u;
    ry = posy - v;
    hx = int'(blit_cfg.view_width) + 2 * offx + s;
    hy = int'(blit_cfg.view_height) + 2 * offy + s;
    tx = -offx - s + int'($urandom_range(0, hx));
    ty = -offy - s + int'($urandom_range(0, hy));
    ox = tx - u * s;
    oy = ty - v * s;
    if (ox < -2048) ox = -2048;
    if (ox > 2047) ox = 2047;
    if (oy < -2048) oy = -2048;
    if (oy > 2047) oy = 2047;
    t = make_texel(ox, oy, rx, ry, u, v, iw, ih,
                   ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 128)) : 128,
                   int'($urandom_range(0, PALETTE_ENTRIES - 1)));
    if (kind == TEXEL_BROKEN) begin
      case ($urandom_range(0, 3))
        0: t.mask_byte = 8'($urandom_range(129, 255));
        1: t.color = 8'($urandom_range(PALETTE_ENTRIES, 255));
        2: t.image_width = 13'(posx - int'($urandom_range(0, (posx < 3) ? posx : 3)));
        default: t.image_height = 13'(posy - int'($urandom_range(0, (posy < 3) ? posy : 3)));
      endcase
    end
    return t;
  endfunction

  // Called at a clock edge; valid is only lowered when a gap is actually taken.
  task automatic send_texel(texel_t t, output int n_writes);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= t.origin_x;
    origin_y_i <= t.origin_y;
    rect_x_i <= t.rect_x;
    rect_y_i <= t.rect_y;
    texel_u_i <= t.texel_u;
    texel_v_i <= t.texel_v;
    image_width_i <= t.image_width;
    image_height_i <= t.image_height;
    mask_byte_i <= t.mask_byte;
    color_i <= t.color;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    n_writes = expand_texel(t);
    texels_sent++;
    if (n_writes < 0) texels_dropped++;
    else if (n_writes == 0) texels_clipped++;
  endtask

  // Stop sending, let every expected write arrive, then give dropped or clipped texels
  // time to leave the sequencer.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_BITS-1:0] idx, int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_DATA_BITS'(data);
    @(posedge clk_i);
  endtask

  task automatic load_settings(cfg_t c);
    wait_idle();
    put_reg(REG_SCALE, int'(c.scale));
    put_reg(REG_DRAW_OUTSIDE, int'(c.draw_outside));
    put_reg(REG_MARGIN_X, int'(c.margin_x));
    put_reg(REG_MARGIN_Y, int'(c.margin_y));
    put_reg(REG_VIEW_WIDTH, int'(c.view_width));
    put_reg(REG_VIEW_HEIGHT, int'(c.view_height));
    put_reg(REG_LINE_PITCH, int'(c.line_pitch));
    cfg_we_i <= 1'b0;
    blit_cfg = c;
    settings_loaded++;
  endtask

  // Reset defaults: scale 2, 640 x 480 viewport, pitch 640, no margins.
  task automatic test_reset_defaults();
    int n;
    send_texel(make_texel(0, 0, 0, 0, 0, 0, 64, 64, 0, 1), n);
    send_texel(make_texel(10, 20, 5, 6, 3, 2, 64, 64, 128, 15), n);
    send_texel(make_texel(10, 20, 5, 6, 3, 2, 64, 64, 129, 3), n);
    send_texel(make_texel(10, 20, 5, 6, 3, 2, 64, 64, 255, 3), n);
    send_texel(make_texel(10, 20, 5, 6, 3, 2, 64, 64, 7, 16), n);
    send_texel(make_texel(10, 20, 5, 6, 3, 2, 64, 64, 7, 255), n);
    send_texel(make_texel(-200, -100, 0, 0, 255, 255, 256, 256, 0, 0), n);
    send_texel(make_texel(4, 4, 100, 0, 5, 0, 105, 64, 0, 2), n);
    send_texel(make_texel(4, 4, 0, 100, 0, 5, 64, 105, 0, 2), n);
    send_texel(make_texel(4, 4, 0, 0, 0, 0, 0, 64, 0, 2), n);
    send_texel(make_texel(30, 40, 4095, 4095, 0, 0, 4096, 4096, 64, 9), n);
    send_texel(make_texel(-1, -1, 0, 0, 0, 0, 8, 8, 0, 4), n);
    send_texel(make_texel(639, 479, 0, 0, 0, 0, 8, 8, 0, 5), n);
    send_texel(make_texel(-2048, -2048, 0, 0, 0, 0, 8, 8, 0, 6), n);
    send_texel(make_texel(2047, 2047, 0, 0, 0, 0, 8, 8, 0, 7), n);
    send_texel(make_texel(-500, -500, 4095, 4095, 255, 255, 8191, 8191, 100, 8), n);
    wait_idle();
  endtask

  // Scale zero and saturation, zero pitch, empty viewport, largest margins with wrapping.
  task automatic test_special_settings();
    int n;
    load_settings(make_settings(0, 0, 0, 0, 2047, 2047, 4096));
    send_texel(make_texel(2046, 2046, 0, 0, 0, 0, 8, 8, 0, 3), n);
    load_settings(make_settings(15, 1, 1023, 1023, 2047, 2047, 8191));
    send_texel(make_texel(2040, 2040, 0, 0, 0, 0, 8, 8, 0, 11), n);
    send_texel(make_texel(-1027, -1026, 0, 0, 0, 0, 8, 8, 0, 12), n);
    load_settings(make_settings(3, 1, 5, 7, 100, 50, 0));
    send_texel(make_texel(-6, -8, 0, 0, 0, 0, 8, 8, 0, 13), n);
    load_settings(make_settings(2, 0, 4, 4, 0, 0, 640));
    send_texel(make_texel(0, 0, 0, 0, 0, 0, 8, 8, 0, 14), n);
    load_settings(make_settings(2, 1, 2, 2, 0, 0, 16));
    send_texel(make_texel(-2, -2, 0, 0, 0, 0, 8, 8, 0, 1), n);
    load_settings(make_settings(8, 0, 0, 0, 1, 1, 1));
    send_texel(make_texel(0, 0, 0, 0, 0, 0, 8, 8, 0, 2), n);
    wait_idle();
  endtask

  // Phases of random settings, each phase a short run of mixed good, broken and noise texels.
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    int kept, in_phase, phase_len, r, n;
    texel_t t;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    kept = 0;
    while (kept < n_items) begin
      load_settings(random_settings());
      phase_len = int'($urandom_range(8, 20));
      in_phase = 0;
      while (in_phase < phase_len && kept < n_items) begin
        r = int'($urandom_range(0, 99));
        if (r < 75) t = random_texel(TEXEL_GOOD);
        else if (r < 88) t = random_texel(TEXEL_BROKEN);
        else t = random_texel(TEXEL_NOISE);
        send_texel(t, n);
        kept++;
        in_phase++;
      end
    end
    wait_idle();
  endtask

  always @(posedge clk_i) begin : check_writes
    layer_write_t w;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_writes.size() == 0) begin
        $error("write beat with none expected: address %0d color %0d last %0b",
               write_address_o, write_color_o, last_o);
        error_count++;
      end else begin
        w = expected_writes.pop_front();
        writes_checked++;
        if (write_address_o !== w.address) begin
          $error("write_address: expected %0d, got %0d", w.address, write_address_o);
          error_count++;
        end
        if (write_color_o !== w.color) begin
          $error("write_color: expected %0d, got %0d", w.color, write_color_o);
          error_count++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, last_o);
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no beat accepted for %0d cycles, %0d writes outstanding", quiet_cycles,
             expected_writes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    blit_cfg = make_settings(2, 0, 0, 0, 640, 480, 640);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_special_settings();
    test_random_traffic(32, 74, 70);
    test_random_traffic(74, 32, 70);
    test_random_traffic(0, 0, 70);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d texels (%0d dropped, %0d fully clipped) over %0d register settings.",
             texels_sent, texels_dropped, texels_clipped, settings_loaded);
    $display("Checked %0d layer writes with %0d mismatches.", writes_checked, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
sv/msblit_pkg.sv
sv/msblit_cfg.sv
sv/msblit_ctrl.sv
sv/msblit_dp.sv
sv/masked_scaled_sprite_blit_top.sv
test/tb_top.sv
